/* design/lirs_pkg.sv */
// shared constants and types for the three-axis linear interpolation resampler
package lirs_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int FRAC_BITS    = 16;
	localparam int NUM_AXES     = 3;
	localparam int STEP_W       = 4 + FRAC_BITS;
	localparam int PHASE_W      = FRAC_BITS + 6;
	localparam int FRAC_W       = FRAC_BITS + 1;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [STEP_W-1:0]              step_t;
	typedef logic signed [PHASE_W-1:0]      phase_t;
	typedef logic [FRAC_W-1:0]              frac_t;

	localparam step_t STEP_RESET =
		STEP_W'(((64'd260 << FRAC_BITS) + 64'd122) / 64'd244);
	localparam step_t  STEP_ONE  = STEP_W'(64'd1 << FRAC_BITS);
	localparam phase_t PHASE_ONE = PHASE_W'(64'd1 << FRAC_BITS);
	localparam frac_t  FRAC_ONE  = FRAC_W'(64'd1 << FRAC_BITS);

endpackage

/* design/lirs_if.sv */
// stream interfaces for input samples and resampled output
interface lirs_in_if;
	import lirs_pkg::*;

	logic    valid;
	logic    ready;
	logic    restart;
	sample_t sample_x;
	sample_t sample_y;
	sample_t sample_z;

	modport source (output valid, output restart, output sample_x, output sample_y,
		output sample_z, input ready);
	modport sink (input valid, input restart, input sample_x, input sample_y,
		input sample_z, output ready);
endinterface

interface lirs_out_if;
	import lirs_pkg::*;

	logic    valid;
	logic    ready;
	sample_t out_x;
	sample_t out_y;
	sample_t out_z;

	modport source (output valid, output out_x, output out_y, output out_z, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

/* design/lirs_axis.sv */
// per-axis interpolation datapath with half-up rounding
module lirs_axis (
	input  lirs_pkg::sample_t prev,
	input  lirs_pkg::sample_t cur,
	input  lirs_pkg::frac_t   frac,
	input  logic              first,
	output lirs_pkg::sample_t result
);
	import lirs_pkg::*;

	localparam int PROD_W = SAMPLE_WIDTH + FRAC_BITS + 3;
	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));

	logic signed [SAMPLE_WIDTH:0] diff;
	logic signed [PROD_W-1:0]     prod;
	logic signed [PROD_W-1:0]     rnd;
	logic signed [PROD_W-1:0]     shifted;
	sample_t                      interp;

	assign diff    = $signed({cur[SAMPLE_WIDTH-1], cur}) - $signed({prev[SAMPLE_WIDTH-1], prev});
	assign prod    = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));
	assign rnd     = prod + HALF;
	assign shifted = rnd >>> FRAC_BITS;
	assign interp  = sample_t'(prev + $signed(shifted[SAMPLE_WIDTH-1:0]));
	assign result  = first ? cur : interp;

endmodule

/* design/linear_interp_resampler_3axis_unit.sv */
// top level of the three-axis linear interpolation resampler
//
// samples: one three-axis signed sample per beat, with a restart flag that
//   makes this sample the first of a new stream
// resampled: zero or one interpolated sample per input beat
// cfg_we/cfg_wdata: write of the Q4.16 step (input periods per output),
//   values below 1.0 act as 1.0; write only while the block is idle
// latency: an input beat accepted at edge n gives its result on resampled
//   from edge n+2 (input register, then the result register)
// throughput: one input beat per cycle; the phase update and three
//   17x17 multiplies sit between the input register and the result register
// the first sample after reset or restart is passed through unchanged
// reset: clears the step to its default (about 26.0/24.4), the phase and the
//   first-sample flag; no result is pending afterward
// stall: while a result waits on resampled the pipe holds, and samples still
//   takes one beat into its input register if that register is empty
module linear_interp_resampler_3axis_unit (
	input  logic                clk,
	input  logic                arst_n,
	lirs_in_if.sink             samples,
	lirs_out_if.source          resampled,
	input  logic                cfg_we,
	input  lirs_pkg::step_t     cfg_wdata
);
	import lirs_pkg::*;

	localparam phase_t PHASE_MIN = -PHASE_ONE;

	step_t   step_q;
	logic    valid_s1;
	logic    restart_s1;
	sample_t samp_s1 [NUM_AXES];
	sample_t curr_q [NUM_AXES];
	phase_t  phase_q;
	logic    seen_q;
	logic    out_valid_q;
	sample_t out_q [NUM_AXES];

	logic    adv;
	logic    go;
	logic    first;
	logic    fire;
	step_t   eff_step;
	phase_t  step_ext;
	phase_t  phase_m;
	phase_t  phase_next;
	frac_t   frac;
	sample_t res [NUM_AXES];

	assign adv           = !out_valid_q || resampled.ready;
	assign samples.ready = !valid_s1 || adv;
	assign go            = valid_s1 && adv;

	assign first    = restart_s1 || !seen_q;
	assign eff_step = (step_q < STEP_ONE) ? STEP_ONE : step_q;
	assign step_ext = $signed(PHASE_W'(eff_step));
	assign phase_m  = phase_q - PHASE_ONE;
	assign fire     = first || (phase_m <= 0);

	always_comb begin
		if (phase_q < 0) begin
			frac = '0;
		end else if (phase_q > PHASE_ONE) begin
			frac = FRAC_ONE;
		end else begin
			frac = phase_q[FRAC_W-1:0];
		end
		if (first) begin
			phase_next = step_ext;
		end else if (fire) begin
			phase_next = phase_m + step_ext;
		end else begin
			phase_next = phase_m;
		end
	end

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		lirs_axis u_axis (
			.prev   (curr_q[a]),
			.cur    (samp_s1[a]),
			.frac   (frac),
			.first  (first),
			.result (res[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_RESET;
			valid_s1    <= 1'b0;
			seen_q      <= 1'b0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_q <= cfg_wdata;
			end
			if (samples.ready) begin
				valid_s1 <= samples.valid;
			end
			if (adv) begin
				out_valid_q <= go && fire;
			end
			if (go) begin
				seen_q  <= 1'b1;
				phase_q <= phase_next;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			restart_s1 <= samples.restart;
			samp_s1[0] <= samples.sample_x;
			samp_s1[1] <= samples.sample_y;
			samp_s1[2] <= samples.sample_z;
		end
		if (go) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				curr_q[a] <= samp_s1[a];
			end
		end
		if (go && fire) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				out_q[a] <= res[a];
			end
		end
	end

	assign resampled.valid = out_valid_q;
	assign resampled.out_x = out_q[0];
	assign resampled.out_y = out_q[1];
	assign resampled.out_z = out_q[2];

	// a first sample always yields a result
	a_first_out: assert property (@(posedge clk) disable iff (!arst_n)
		go && first |=> out_valid_q)
		else $error("first sample gave no result");

	// restart forces a result on the next edge
	a_restart_out: assert property (@(posedge clk) disable iff (!arst_n)
		go && restart_s1 |=> out_valid_q)
		else $error("restart sample gave no result");

	// phase stays above minus one sample once running
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> phase_q > PHASE_MIN)
		else $error("phase out of range");

	// no result appears without a sample in the input register
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !valid_s1 |=> !out_valid_q)
		else $error("result without input");

endmodule
